FILE: rtl/core/bsff_pkg.sv
// Shared types, constants and face tables for the box support feature finder.
package bsff_pkg;

    localparam int NUM_CORNERS = 8;
    localparam int IDX_W       = 3;
    localparam int PROJ_W      = 36;
    localparam int ACC_W       = 52;
    localparam int PROD_W      = 50;
    localparam int TOL_W       = 16;

    localparam logic [PROJ_W-1:0] PROJ_MAX_C = {1'b0, {(PROJ_W-1){1'b1}}};
    localparam logic [PROJ_W-1:0] PROJ_MIN_C = {1'b1, {(PROJ_W-1){1'b0}}};
    localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd328;

    // Register index of the tolerance register
    localparam logic REG_TOLERANCE = 1'b0;

    // Feature kind codes
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_EDGE   = 2'd1;
    localparam logic [1:0] KIND_FACE   = 2'd2;
    localparam logic [1:0] KIND_OTHER  = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_TRK,
        ST_PREP,
        ST_EMIT
    } t_state;

    // Control of the shared multiply-accumulate unit
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic       acc_en;
        logic [1:0] sel;
    } t_mac_ctrl;

    typedef struct packed {
        logic       hit;
        logic [2:0] face;
    } t_face_match;

    typedef logic [IDX_W-1:0] t_face_row [4];

    // Fixed corner order of each of the six box faces
    localparam t_face_row FACE_ORDER [6] = '{
        '{3'd0, 3'd2, 3'd3, 3'd1},
        '{3'd4, 3'd5, 3'd7, 3'd6},
        '{3'd0, 3'd4, 3'd6, 3'd2},
        '{3'd1, 3'd3, 3'd7, 3'd5},
        '{3'd0, 3'd1, 3'd5, 3'd4},
        '{3'd2, 3'd6, 3'd7, 3'd3}
    };

    // Find the face whose full set, a triple of it or one diagonal equals the mask
    function automatic t_face_match match_face(input logic [NUM_CORNERS-1:0] mask);
        t_face_match              res;
        logic [NUM_CORNERS-1:0]   full;
        logic                     hit;
        res = '0;
        for (int f = 0; f < 6; f++) begin
            full = '0;
            for (int k = 0; k < 4; k++) begin
                full = full | (NUM_CORNERS'(1) << FACE_ORDER[f][k]);
            end
            hit = (mask == full);
            for (int k = 0; k < 4; k++) begin
                if (mask == (full & ~(NUM_CORNERS'(1) << FACE_ORDER[f][k]))) begin
                    hit = 1'b1;
                end
            end
            if (mask == ((NUM_CORNERS'(1) << FACE_ORDER[f][0]) |
                         (NUM_CORNERS'(1) << FACE_ORDER[f][2]))) begin
                hit = 1'b1;
            end
            if (mask == ((NUM_CORNERS'(1) << FACE_ORDER[f][1]) |
                         (NUM_CORNERS'(1) << FACE_ORDER[f][3]))) begin
                hit = 1'b1;
            end
            if (hit) begin
                res.hit  = 1'b1;
                res.face = 3'(f);
            end
        end
        return res;
    endfunction

    // Count the members of a corner mask
    function automatic logic [IDX_W:0] count_members(input logic [NUM_CORNERS-1:0] mask);
        logic [IDX_W:0] cnt;
        cnt = '0;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            cnt = cnt + {{IDX_W{1'b0}}, mask[i]};
        end
        return cnt;
    endfunction

    // Index of the lowest member of a corner mask
    function automatic logic [IDX_W-1:0] lowest_member(input logic [NUM_CORNERS-1:0] mask);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = NUM_CORNERS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: rtl/core/bsff_mac.sv
// Shared multiply-accumulate unit that forms one corner projection over three products.
module bsff_mac
    import bsff_pkg::*;
(
    input  logic                     i_clk,
    input  t_mac_ctrl                i_ctrl,
    input  logic signed [31:0]       i_vertex_x,
    input  logic signed [31:0]       i_vertex_y,
    input  logic signed [31:0]       i_vertex_z,
    input  logic signed [17:0]       i_axis_x,
    input  logic signed [17:0]       i_axis_y,
    input  logic signed [17:0]       i_axis_z,
    output logic signed [PROJ_W-1:0] o_proj
);

    logic signed [31:0]       r_vx, r_vy, r_vz;
    logic signed [17:0]       r_ax, r_ay, r_az;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [31:0]       w_v;
    logic signed [17:0]       w_a;
    logic signed [PROD_W-1:0] w_prod;

    // Pick the component pair for this step
    always_comb begin
        case (i_ctrl.sel)
            2'd0:    begin w_v = r_vx; w_a = r_ax; end
            2'd1:    begin w_v = r_vy; w_a = r_ay; end
            default: begin w_v = r_vz; w_a = r_az; end
        endcase
    end

    assign w_prod = w_v * w_a;

    // Latch operands, multiply, accumulate
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_vx  <= i_vertex_x;
            r_vy  <= i_vertex_y;
            r_vz  <= i_vertex_z;
            r_ax  <= i_axis_x;
            r_ay  <= i_axis_y;
            r_az  <= i_axis_z;
            r_acc <= '0;
        end else if (i_ctrl.acc_en) begin
            r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        if (i_ctrl.mul_en) begin
            r_prod <= w_prod;
        end
    end

    // Floor shift by 16: drop the low fraction bits
    assign o_proj = r_acc[ACC_W-1:16];

endmodule

FILE: rtl/core/box_support_feature_finder.sv
// Top level of the box support feature finder: sequencer, corner stores and result port.
//
// Usage: write the tolerance over the APB port (address 0) while the block is idle.
// Present one box corner with its projection axis by raising start while busy is
// low; the item is taken at that clock edge and busy rises for the work on it.
// Each corner must finish three products through the one shared 32x18 multiplier, one
// closing accumulate, and one compare step for each side through the shared
// tolerance/extreme comparator before the next can be started.
// After the eighth corner the block stays busy while it emits the results: one
// preparation step per side, then one result per cycle, min side first, max side
// second; each result appears in the cycle after its corner is read from the store.
// A full set of 8 corners gives N results, N being 2 to 16.
// o_valid marks each result for exactly one cycle; the receiver cannot stall.
// Reset (synchronous, active low) clears the corner count, extremes and member
// sets, and restores the tolerance to its default; the corner stores are not cleared.
module box_support_feature_finder
    import bsff_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [31:0]       i_vertex_x,
    input  logic signed [31:0]       i_vertex_y,
    input  logic signed [31:0]       i_vertex_z,
    input  logic signed [17:0]       i_axis_x,
    input  logic signed [17:0]       i_axis_y,
    input  logic signed [17:0]       i_axis_z,
    output logic                     o_valid,
    output logic                     o_side,
    output logic signed [PROJ_W-1:0] o_projection,
    output logic [1:0]               o_feature_kind,
    output logic [2:0]               o_corner_index,
    output logic signed [31:0]       o_corner_x,
    output logic signed [31:0]       o_corner_y,
    output logic signed [31:0]       o_corner_z,
    output logic                     o_side_last,
    output logic                     o_set_last,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    t_state                 r_state, n_state;
    logic [1:0]             r_step, n_step;
    logic                   r_side, n_side;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [PROJ_W-1:0]      r_lo, n_lo;
    logic [PROJ_W-1:0]      r_hi, n_hi;
    logic [NUM_CORNERS-1:0] r_lom, n_lom;
    logic [NUM_CORNERS-1:0] r_him, n_him;
    logic [NUM_CORNERS-1:0] r_rem, n_rem;
    logic [1:0]             r_k, n_k;
    logic [IDX_W:0]         r_cnt, n_cnt;
    logic                   r_fhit, n_fhit;
    logic [2:0]             r_face, n_face;
    logic [TOL_W-1:0]       r_tol;
    logic                   r_valid;

    logic [31:0] x_mem [NUM_CORNERS];
    logic [31:0] y_mem [NUM_CORNERS];
    logic [31:0] z_mem [NUM_CORNERS];

    t_mac_ctrl              w_mac;
    logic signed [PROJ_W-1:0] w_proj;
    logic                   w_accept;
    logic                   w_cfg_wr;
    logic [PROJ_W-1:0]      w_ext;
    logic [PROJ_W:0]        w_diff;
    logic [PROJ_W:0]        w_mag;
    logic                   w_join;
    logic                   w_beyond;
    logic [NUM_CORNERS-1:0] w_bit;
    logic [NUM_CORNERS-1:0] w_mask;
    t_face_match            w_fm;
    logic [IDX_W-1:0]       w_corner;
    logic                   w_last;
    logic                   w_emit;
    logic [1:0]             w_kind;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // Shared projection datapath
    bsff_mac u_mac (
        .i_clk      (i_clk),
        .i_ctrl     (w_mac),
        .i_vertex_x (i_vertex_x),
        .i_vertex_y (i_vertex_y),
        .i_vertex_z (i_vertex_z),
        .i_axis_x   (i_axis_x),
        .i_axis_y   (i_axis_y),
        .i_axis_z   (i_axis_z),
        .o_proj     (w_proj)
    );

    // Shared comparator: distance and direction against the side's extreme
    assign w_ext    = r_side ? r_hi : r_lo;
    assign w_diff   = {w_ext[PROJ_W-1], w_ext} - {w_proj[PROJ_W-1], w_proj};
    assign w_mag    = w_diff[PROJ_W] ? (~w_diff + 1'b1) : w_diff;
    assign w_join   = w_mag < {{(PROJ_W+1-TOL_W){1'b0}}, r_tol};
    assign w_beyond = r_side ? w_diff[PROJ_W] : (!w_diff[PROJ_W] && (w_diff != '0));
    assign w_bit    = NUM_CORNERS'(1) << r_idx;

    // Face lookup for the side being prepared
    assign w_mask = r_side ? r_him : r_lom;
    assign w_fm   = match_face(w_mask);

    // Corner picked for this result cycle; last is the fourth face corner or the only member left
    assign w_corner = r_fhit ? FACE_ORDER[r_face][r_k] : lowest_member(r_rem);
    assign w_last   = r_fhit ? (r_k == 2'd3) : ((r_rem & (r_rem - 1'b1)) == '0);
    assign w_emit   = (r_state == ST_EMIT);

    always_comb begin
        case (r_cnt)
            4'd1:    w_kind = KIND_VERTEX;
            4'd2:    w_kind = KIND_EDGE;
            4'd4:    w_kind = KIND_FACE;
            default: w_kind = KIND_OTHER;
        endcase
    end

    // Sequencer: next state and unit control
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_side  = r_side;
        n_idx   = r_idx;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_lom   = r_lom;
        n_him   = r_him;
        n_rem   = r_rem;
        n_k     = r_k;
        n_cnt   = r_cnt;
        n_fhit  = r_fhit;
        n_face  = r_face;
        w_mac   = '0;
        w_mac.sel = r_step;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_mac.load = 1'b1;
                    n_step     = 2'd0;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                w_mac.mul_en = 1'b1;
                w_mac.acc_en = (r_step != 2'd0);
                n_step       = r_step + 2'd1;
                if (r_step == 2'd2) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                w_mac.acc_en = 1'b1;
                n_side       = 1'b0;
                n_state      = ST_TRK;
            end
            ST_TRK: begin
                // Join within tolerance, else restart the set when strictly beyond
                if (r_side) begin
                    if (w_join) begin
                        n_him = r_him | w_bit;
                    end else if (w_beyond) begin
                        n_him = w_bit;
                        n_hi  = w_proj;
                    end
                end else begin
                    if (w_join) begin
                        n_lom = r_lom | w_bit;
                    end else if (w_beyond) begin
                        n_lom = w_bit;
                        n_lo  = w_proj;
                    end
                end
                if (!r_side) begin
                    n_side = 1'b1;
                end else if (r_idx == IDX_W'(NUM_CORNERS - 1)) begin
                    n_side  = 1'b0;
                    n_state = ST_PREP;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_PREP: begin
                n_fhit  = w_fm.hit;
                n_face  = w_fm.face;
                n_cnt   = w_fm.hit ? 4'd4 : count_members(w_mask);
                n_rem   = w_mask;
                n_k     = 2'd0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_rem = r_rem & ~(NUM_CORNERS'(1) << w_corner);
                n_k   = r_k + 2'd1;
                if (w_last) begin
                    if (!r_side) begin
                        n_side  = 1'b1;
                        n_state = ST_PREP;
                    end else begin
                        // Drop the set and start over
                        n_side  = 1'b0;
                        n_idx   = '0;
                        n_lo    = PROJ_MAX_C;
                        n_hi    = PROJ_MIN_C;
                        n_lom   = '0;
                        n_him   = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_side  <= 1'b0;
            r_idx   <= '0;
            r_lo    <= PROJ_MAX_C;
            r_hi    <= PROJ_MIN_C;
            r_lom   <= '0;
            r_him   <= '0;
            r_rem   <= '0;
            r_k     <= '0;
            r_cnt   <= '0;
            r_fhit  <= 1'b0;
            r_face  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_side  <= n_side;
            r_idx   <= n_idx;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_lom   <= n_lom;
            r_him   <= n_him;
            r_rem   <= n_rem;
            r_k     <= n_k;
            r_cnt   <= n_cnt;
            r_fhit  <= n_fhit;
            r_face  <= n_face;
            r_valid <= w_emit;
        end
    end

    // Tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (w_cfg_wr && (paddr[2] == REG_TOLERANCE)) begin
            r_tol <= pwdata[TOL_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TOLERANCE) ? {{(32-TOL_W){1'b0}}, r_tol} : 32'd0;

    // Corner stores: write on accept, registered read into the result port
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            x_mem[r_idx] <= i_vertex_x;
            y_mem[r_idx] <= i_vertex_y;
            z_mem[r_idx] <= i_vertex_z;
        end
        if (w_emit) begin
            o_corner_x <= x_mem[w_corner];
            o_corner_y <= y_mem[w_corner];
            o_corner_z <= z_mem[w_corner];
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_side         <= r_side;
            o_projection   <= w_ext;
            o_feature_kind <= w_kind;
            o_corner_index <= w_corner;
            o_side_last    <= w_last;
            o_set_last     <= w_last && r_side;
        end
    end

    assign o_valid = r_valid;

    // A result only follows an output cycle of the sequencer
    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_EMIT))
        else $error("result strobe without an output cycle");

    // End of set is also the end of the max side
    a_set_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_set_last) |-> (o_side && o_side_last))
        else $error("set end outside the max side's last result");

    // An accepted item makes the block busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("block not busy after accepting an item");

    // Each side has at least one member when its results are prepared
    a_nonempty_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PREP) |-> (w_mask != '0))
        else $error("empty member set at output");

    // The last result of the set returns the block to idle
    a_idle_after_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last && r_side) |=> !busy)
        else $error("block still busy after the set ended");

endmodule

FILE: tb/box_support_feature_finder_tb.sv
// Self-checking testbench for the box support feature finder: corner sets in, support features out.
module box_support_feature_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsff_pkg::*;

    localparam logic [2:0] ADDR_TOLERANCE = 3'd0;
    localparam logic [2:0] ADDR_UNUSED    = 3'd4;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 12;
    localparam longint PROJ_TOP    = (longint'(1) <<< 35) - 1;
    localparam longint PROJ_BOTTOM = -(longint'(1) <<< 35);

    // Corner order of each box face; corner index bits are x, y, z from bit 0 up
    localparam int FACE_CORNERS [6][4] = '{
        '{0, 2, 3, 1}, '{4, 5, 7, 6}, '{0, 4, 6, 2},
        '{1, 3, 7, 5}, '{0, 1, 5, 4}, '{2, 6, 7, 3}
    };

    typedef struct {
        logic signed [31:0] x, y, z;
        logic signed [17:0] ax, ay, az;
    } t_corner;

    typedef struct {
        logic              side;
        logic [PROJ_W-1:0] projection;
        logic [1:0]        kind;
        logic [2:0]        index;
        logic [31:0]       cx, cy, cz;
        logic              side_last;
        logic              set_last;
    } t_box_feature;

    // Tracks extremes and member sets of the current corner set, holds expected features
    class support_feature_tracker;
        logic [15:0]    tolerance;
        logic [31:0]    x_mem [8];
        logic [31:0]    y_mem [8];
        logic [31:0]    z_mem [8];
        int             corner_count;
        longint         low_proj, high_proj;
        logic [7:0]     low_set, high_set;
        t_box_feature   expected_features [$];
        int unsigned    failures;

        function new();
            tolerance = 16'd328;
            failures  = 0;
            clear_set();
        endfunction

        function void clear_set();
            corner_count = 0;
            low_proj     = PROJ_TOP;
            high_proj    = PROJ_BOTTOM;
            low_set      = '0;
            high_set     = '0;
        endfunction

        function void write_register(logic [2:0] addr, logic [31:0] data);
            if (addr == ADDR_TOLERANCE) begin
                tolerance = data[15:0];
            end
        endfunction

        // Exact dot product, then floor shift from Q20.32 down to Q20.16
        function longint project_corner(logic signed [31:0] vx, vy, vz,
                                        logic signed [17:0] ax, ay, az);
            longint acc;
            acc = longint'(vx) * longint'(ax) + longint'(vy) * longint'(ay) +
                  longint'(vz) * longint'(az);
            return acc >>> 16;
        endfunction

        // Join within tolerance first, else restart the set on a strictly better value
        function void update_side(bit is_low, longint p, int idx);
            longint     ext;
            longint     spread;
            logic [7:0] mem;
            ext    = is_low ? low_proj : high_proj;
            mem    = is_low ? low_set : high_set;
            spread = ext - p;
            if (spread < 0) begin
                spread = -spread;
            end
            if (spread < longint'(tolerance)) begin
                mem[idx] = 1'b1;
            end else if (is_low ? (p < ext) : (p > ext)) begin
                mem = 8'(1) << idx;
                ext = p;
            end
            if (is_low) begin
                low_proj = ext;
                low_set  = mem;
            end else begin
                high_proj = ext;
                high_set  = mem;
            end
        endfunction

        // Face that the set fills, covers but one corner of, or spans by a diagonal
        function int face_for_set(logic [7:0] mask);
            int         found;
            logic [7:0] full;
            found = -1;
            for (int f = 0; f < 6; f++) begin
                full = '0;
                for (int k = 0; k < 4; k++) begin
                    full[FACE_CORNERS[f][k]] = 1'b1;
                end
                if (mask == full) begin
                    found = f;
                end
                for (int k = 0; k < 4; k++) begin
                    if (mask == (full & ~(8'(1) << FACE_CORNERS[f][k]))) begin
                        found = f;
                    end
                end
                if (mask == ((8'(1) << FACE_CORNERS[f][0]) | (8'(1) << FACE_CORNERS[f][2])) ||
                    mask == ((8'(1) << FACE_CORNERS[f][1]) | (8'(1) << FACE_CORNERS[f][3]))) begin
                    found = f;
                end
            end
            return found;
        endfunction

        // Queue the features of one side in face order or ascending index
        function void queue_side(bit side, bit final_side);
            int           order [$];
            int           f;
            logic [7:0]   mask;
            longint       ext;
            logic [1:0]   kind;
            t_box_feature r;
            mask = side ? high_set : low_set;
            ext  = side ? high_proj : low_proj;
            f    = face_for_set(mask);
            if (f >= 0) begin
                for (int k = 0; k < 4; k++) begin
                    order = {order, FACE_CORNERS[f][k]};
                end
            end else begin
                for (int i = 0; i < NUM_CORNERS; i++) begin
                    if (mask[i]) begin
                        order = {order, i};
                    end
                end
            end
            case (order.size())
                1: kind = KIND_VERTEX;
                2: kind = KIND_EDGE;
                4: kind = KIND_FACE;
                default: kind = KIND_OTHER;
            endcase
            for (int k = 0; k < order.size(); k++) begin
                r.side       = side;
                r.projection = ext[PROJ_W-1:0];
                r.kind       = kind;
                r.index      = 3'(order[k]);
                r.cx         = x_mem[order[k]];
                r.cy         = y_mem[order[k]];
                r.cz         = z_mem[order[k]];
                r.side_last  = (k == order.size() - 1);
                r.set_last   = final_side && (k == order.size() - 1);
                expected_features = {expected_features, r};
            end
        endfunction

        // Store an accepted corner, update both sides, close the set on the eighth
        function void note_corner(t_corner c);
            int     idx;
            longint p;
            idx        = corner_count;
            x_mem[idx] = c.x;
            y_mem[idx] = c.y;
            z_mem[idx] = c.z;
            p = project_corner(c.x, c.y, c.z, c.ax, c.ay, c.az);
            update_side(1'b1, p, idx);
            update_side(1'b0, p, idx);
            if (idx == NUM_CORNERS - 1) begin
                queue_side(1'b0, 1'b0);
                queue_side(1'b1, 1'b1);
                clear_set();
            end else begin
                corner_count++;
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                failures++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        // Match a result against the oldest expected feature
        function void check_feature(t_box_feature got);
            t_box_feature want;
            if (expected_features.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none actual side %0d corner %0d",
                         $time, got.side, got.index);
                return;
            end
            want = expected_features.pop_front();
            compare_field("side", 64'(want.side), 64'(got.side));
            compare_field("projection", 64'(want.projection), 64'(got.projection));
            compare_field("feature_kind", 64'(want.kind), 64'(got.kind));
            compare_field("corner_index", 64'(want.index), 64'(got.index));
            compare_field("corner_x", 64'(want.cx), 64'(got.cx));
            compare_field("corner_y", 64'(want.cy), 64'(got.cy));
            compare_field("corner_z", 64'(want.cz), 64'(got.cz));
            compare_field("side_last", 64'(want.side_last), 64'(got.side_last));
            compare_field("set_last", 64'(want.set_last), 64'(got.set_last));
        endfunction

        function int pending();
            return expected_features.size();
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [31:0]       i_vertex_x = '0;
    logic signed [31:0]       i_vertex_y = '0;
    logic signed [31:0]       i_vertex_z = '0;
    logic signed [17:0]       i_axis_x = '0;
    logic signed [17:0]       i_axis_y = '0;
    logic signed [17:0]       i_axis_z = '0;
    logic                     o_valid;
    logic                     o_side;
    logic signed [PROJ_W-1:0] o_projection;
    logic [1:0]               o_feature_kind;
    logic [2:0]               o_corner_index;
    logic signed [31:0]       o_corner_x;
    logic signed [31:0]       o_corner_y;
    logic signed [31:0]       o_corner_z;
    logic                     o_side_last;
    logic                     o_set_last;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [2:0]               paddr = '0;
    logic [31:0]              pwdata = '0;
    logic [31:0]              prdata;
    logic                     pready;

    support_feature_tracker tracker = new();
    t_corner     box_corners [8];
    int          burst_left = 0;
    int unsigned quiet_cycles = 0;

    box_support_feature_finder dut (.*);

    always #1 i_clk = ~i_clk;

    // Check every result in the cycle it is shown
    always @(posedge i_clk) begin : monitor_results
        t_box_feature seen;
        if (i_rst_n && o_valid) begin
            seen.side       = o_side;
            seen.projection = o_projection;
            seen.kind       = o_feature_kind;
            seen.index      = o_corner_index;
            seen.cx         = o_corner_x;
            seen.cy         = o_corner_y;
            seen.cz         = o_corner_z;
            seen.side_last  = o_side_last;
            seen.set_last   = o_set_last;
            tracker.check_feature(seen);
        end
    end

    // End the run once nothing has moved for too long
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid || (psel && penable)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("status: fail");
        $finish;
    end

    // Run one register access: setup cycle, then access until pready
    task automatic apb_access(input logic write, input logic [2:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (write) begin
            tracker.write_register(addr, data);
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write the tolerance and read it back
    task automatic set_tolerance(input logic [31:0] value);
        logic [31:0] readback;
        apb_access(1'b1, ADDR_TOLERANCE, value, readback);
        apb_access(1'b0, ADDR_TOLERANCE, '0, readback);
        if (readback !== {16'd0, tracker.tolerance}) begin
            tracker.failures++;
            $display("%0t: tolerance readback mismatch, expected %0h actual %0h",
                     $time, {16'd0, tracker.tolerance}, readback);
        end
    endtask

    // Drop start and wait until every expected feature has come and the block is idle
    task automatic wait_quiet();
        @(negedge i_clk);
        start = 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Present one corner after an optional gap between bursts, hold until taken
    task automatic send_corner(input t_corner c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge i_clk);
                start = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        start      = 1'b1;
        i_vertex_x = c.x;
        i_vertex_y = c.y;
        i_vertex_z = c.z;
        i_axis_x   = c.ax;
        i_axis_y   = c.ay;
        i_axis_z   = c.az;
        do @(posedge i_clk); while (busy);
        tracker.note_corner(c);
    endtask

    task automatic send_set();
        for (int i = 0; i < NUM_CORNERS; i++) begin
            send_corner(box_corners[i]);
        end
    endtask

    // Lay out an axis-aligned box, one shared axis for all corners
    task automatic fill_box(input int cx, cy, cz, hx, hy, hz,
                            input logic signed [17:0] ax, ay, az);
        for (int i = 0; i < NUM_CORNERS; i++) begin
            box_corners[i].x  = cx + (i[0] ? hx : -hx);
            box_corners[i].y  = cy + (i[1] ? hy : -hy);
            box_corners[i].z  = cz + (i[2] ? hz : -hz);
            box_corners[i].ax = ax;
            box_corners[i].ay = ay;
            box_corners[i].az = az;
        end
    endtask

    // Build one random corner set: mostly boxes, some of them jittered, some noise
    task automatic random_set();
        int pick, axis_sel, mag, span, off;
        int cx, cy, cz, hx, hy, hz;
        logic signed [17:0] axis [3];
        pick     = $urandom_range(0, 99);
        axis_sel = $urandom_range(0, 2);
        cx = int'($urandom_range(0, 1 << 25)) - (1 << 24);
        cy = int'($urandom_range(0, 1 << 25)) - (1 << 24);
        cz = int'($urandom_range(0, 1 << 25)) - (1 << 24);
        hx = $urandom_range(1 << 16, 1 << 22);
        hy = $urandom_range(1 << 16, 1 << 22);
        hz = $urandom_range(1 << 16, 1 << 22);
        mag = ($urandom_range(0, 1) == 0 || (pick >= 20 && pick < 55)) ? 65536
                                                                      : $urandom_range(1, 131071);
        axis = '{default: '0};
        axis[axis_sel] = 18'($urandom_range(0, 1) ? -mag : mag);
        if (pick >= 55 && pick < 70) begin
            axis[0] = 18'($urandom);
            axis[1] = 18'($urandom);
            axis[2] = 18'($urandom);
        end
        fill_box(cx, cy, cz, hx, hy, hz, axis[0], axis[1], axis[2]);
        if (pick >= 20 && pick < 55) begin
            // Scatter each corner around its face by up to twice the tolerance plus four
            span = 2 * int'(tracker.tolerance) + 4;
            for (int i = 0; i < NUM_CORNERS; i++) begin
                off = int'($urandom_range(0, 2 * span)) - span;
                case (axis_sel)
                    0: box_corners[i].x = box_corners[i].x + off;
                    1: box_corners[i].y = box_corners[i].y + off;
                    default: box_corners[i].z = box_corners[i].z + off;
                endcase
            end
        end else if (pick >= 70 && pick < 80) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                box_corners[i].ax = 18'($urandom);
                box_corners[i].ay = 18'($urandom);
                box_corners[i].az = 18'($urandom);
            end
        end else if (pick >= 80) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                box_corners[i].x  = $urandom;
                box_corners[i].y  = $urandom;
                box_corners[i].z  = $urandom;
                box_corners[i].ax = 18'($urandom);
                box_corners[i].ay = 18'($urandom);
                box_corners[i].az = 18'($urandom);
            end
        end
    endtask

    function automatic logic [31:0] random_tolerance();
        case ($urandom_range(0, 4))
            0: return 32'd0;
            1: return 32'h0000_FFFF;
            2: return 32'd328;
            3: return $urandom;
            default: return $urandom_range(1, 4000);
        endcase
    endfunction

    initial begin
        logic [31:0] unused_rd;

        // Hold reset, then release it
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Default tolerance, box faces square to the x axis
        fill_box(1 << 16, -(2 << 16), 7, 1 << 18, 3 << 16, 5 << 16, 18'sd65536, '0, '0);
        send_set();

        // Widest tolerance, ignored write to an unused address, extreme field values
        wait_quiet();
        set_tolerance(32'h0000_FFFF);
        apb_access(1'b1, ADDR_UNUSED, 32'h0000_1234, unused_rd);
        for (int i = 0; i < NUM_CORNERS; i++) begin
            box_corners[i].x  = i[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            box_corners[i].y  = i[1] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            box_corners[i].z  = i[2] ? 32'sh0000_0000 : 32'shFFFF_FFFF;
            box_corners[i].ax = i[0] ? -18'sd131072 : 18'sd131071;
            box_corners[i].ay = i[0] ? 18'sd131071 : -18'sd131072;
            box_corners[i].az = i[0] ? -18'sd131072 : 18'sd131071;
        end
        send_set();

        // Zero tolerance: equal projections are dropped, negative axis along z
        wait_quiet();
        set_tolerance(32'd0);
        fill_box(-(3 << 16), 5 << 16, -(9 << 16) + 3, 2 << 16, 2 << 16, 1 << 16,
                 '0, '0, -18'sd65536);
        send_set();

        wait_quiet();
        set_tolerance(32'd328);

        // Random sets, tolerance changed now and then between sets
        for (int s = 0; s < 11; s++) begin
            if (s > 0 && $urandom_range(0, 2) == 0) begin
                wait_quiet();
                set_tolerance(random_tolerance());
            end
            random_set();
            send_set();
        end

        wait_quiet();
        if (tracker.failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: box_support_feature_finder.f
rtl/core/bsff_pkg.sv
rtl/core/bsff_mac.sv
rtl/core/box_support_feature_finder.sv
tb/box_support_feature_finder_tb.sv
